### rtl/crce_pkg.sv
`timescale 1ns / 1ps

package crce_pkg;

   localparam int CsrIndexWidth = 3;
   localparam logic [CsrIndexWidth-1:0] CSR_CRC_WIDTH      = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_POLYNOMIAL     = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_INITIAL_VALUE  = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_REFLECT_INPUT  = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_REFLECT_OUTPUT = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_FINAL_XOR      = 3'd5;

   localparam logic [5:0]  RESET_CRC_WIDTH      = 6'd32;
   localparam logic [31:0] RESET_POLYNOMIAL     = 32'h04C1_1DB7;
   localparam logic [31:0] RESET_INITIAL_VALUE  = 32'hFFFF_FFFF;
   localparam logic        RESET_REFLECT_INPUT  = 1'b1;
   localparam logic        RESET_REFLECT_OUTPUT = 1'b1;
   localparam logic [31:0] RESET_FINAL_XOR      = 32'hFFFF_FFFF;

   localparam logic [5:0] MinWidth = 6'd8;
   localparam logic [5:0] MaxWidth = 6'd32;

   // middle queue between front and back
   localparam int QueueDepth    = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   // result buffer in the back
   localparam int OutDepth    = 2;
   localparam int OutPtrWidth = $clog2(OutDepth);
   localparam int OutCntWidth = $clog2(OutDepth + 1);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } item_type;

   typedef struct packed {
      logic [5:0]  crc_width;
      logic [31:0] polynomial;
      logic [31:0] initial_value;
      logic        reflect_input;
      logic        reflect_output;
      logic [31:0] final_xor;
   } cfg_type;

   function automatic logic [7:0] reverse8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = v[7-i];
      end
      return r;
   endfunction

   function automatic logic [31:0] reverse32(input logic [31:0] v);
      logic [31:0] r;
      for (int i = 0; i < 32; i++) begin
         r[i] = v[31-i];
      end
      return r;
   endfunction

   // clamp the programmed width into 8..32
   function automatic logic [5:0] eff_width(input logic [5:0] w);
      logic [5:0] r;
      if (w < MinWidth) begin
         r = MinWidth;
      end else if (w > MaxWidth) begin
         r = MaxWidth;
      end else begin
         r = w;
      end
      return r;
   endfunction

   function automatic logic [31:0] width_mask(input logic [5:0] w);
      logic [31:0] m;
      if (w >= MaxWidth) begin
         m = 32'hFFFF_FFFF;
      end else begin
         m = (32'd1 << w) - 32'd1;
      end
      return m;
   endfunction

endpackage

### rtl/crce_front.sv
`timescale 1ns / 1ps

module crce_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  logic [7:0]          req_data_byte,
   input  logic                req_last_byte,
   output logic                req_full,
   input  logic                reflect_input,
   output logic                q_push,
   output crce_pkg::item_type  q_item,
   input  logic                q_full
);

   logic               valid_ff;
   logic               valid_in;
   crce_pkg::item_type item_ff;
   crce_pkg::item_type item_in;
   logic               accept;

   assign q_push   = valid_ff && !q_full;
   assign req_full = valid_ff && q_full;
   assign accept   = req_push && !req_full;
   assign q_item   = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (q_push) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in = 1'b1;
         // put the byte in MSB-first order here so the back sees one form
         item_in.data_byte = reflect_input ? crce_pkg::reverse8(req_data_byte)
                                           : req_data_byte;
         item_in.last_byte = req_last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

### rtl/crce_queue.sv
`timescale 1ns / 1ps

module crce_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  crce_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output crce_pkg::item_type pop_item,
   output logic               empty
);

   crce_pkg::item_type                  mem_ff [crce_pkg::QueueDepth];
   logic [crce_pkg::QueuePtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [crce_pkg::QueuePtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [crce_pkg::QueueCntWidth-1:0] count_ff, count_in;
   logic                                do_push, do_pop;

   assign full     = count_ff == crce_pkg::QueueCntWidth'(crce_pkg::QueueDepth);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### rtl/crce_back.sv
`timescale 1ns / 1ps

module crce_back (
   input  logic               clock,
   input  logic               reset,
   input  crce_pkg::cfg_type  cfg,
   input  logic               q_empty,
   input  crce_pkg::item_type q_item,
   output logic               q_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [31:0]        rsp_crc_value
);

   logic [31:0] remainder_ff, remainder_in;
   logic        in_message_ff, in_message_in;

   logic [31:0]                       out_mem_ff [crce_pkg::OutDepth];
   logic [crce_pkg::OutPtrWidth-1:0] out_wr_ff, out_wr_in;
   logic [crce_pkg::OutPtrWidth-1:0] out_rd_ff, out_rd_in;
   logic [crce_pkg::OutCntWidth-1:0] out_cnt_ff, out_cnt_in;
   logic                              out_full, out_push, out_pop;

   logic [5:0]  width;
   logic [31:0] mask, top, poly, start, r, crc;

   assign width = crce_pkg::eff_width(cfg.crc_width);
   assign mask  = crce_pkg::width_mask(width);
   assign top   = 32'd1 << (width - 6'd1);
   assign poly  = cfg.polynomial & mask;
   assign start = in_message_ff ? remainder_ff : cfg.initial_value;

   assign out_full  = out_cnt_ff == crce_pkg::OutCntWidth'(crce_pkg::OutDepth);
   assign rsp_empty = out_cnt_ff == '0;
   assign out_pop   = rsp_pop && !rsp_empty;

   // hold a last word back while the result buffer has no room
   assign q_pop    = !q_empty && (!q_item.last_byte || !out_full);
   assign out_push = q_pop && q_item.last_byte;

   assign rsp_crc_value = out_mem_ff[out_rd_ff];

   always_comb begin
      r = (start & mask) ^ ({24'd0, q_item.data_byte} << (width - crce_pkg::MinWidth));
      for (int i = 0; i < 8; i++) begin
         if ((r & top) != 32'd0) begin
            r = ((r << 1) ^ poly) & mask;
         end else begin
            r = (r << 1) & mask;
         end
      end
      crc = cfg.reflect_output ? crce_pkg::reverse32(r) >> (crce_pkg::MaxWidth - width) : r;
      crc = (crc ^ cfg.final_xor) & mask;
   end

   always_comb begin
      remainder_in  = remainder_ff;
      in_message_in = in_message_ff;
      if (q_pop) begin
         remainder_in  = q_item.last_byte ? (cfg.initial_value & mask) : r;
         in_message_in = !q_item.last_byte;
      end
      out_wr_in  = out_push ? out_wr_ff + 1'b1 : out_wr_ff;
      out_rd_in  = out_pop ? out_rd_ff + 1'b1 : out_rd_ff;
      out_cnt_in = out_cnt_ff;
      if (out_push && !out_pop) begin
         out_cnt_in = out_cnt_ff + 1'b1;
      end else if (out_pop && !out_push) begin
         out_cnt_in = out_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remainder_ff  <= '0;
         in_message_ff <= 1'b0;
         out_wr_ff     <= '0;
         out_rd_ff     <= '0;
         out_cnt_ff    <= '0;
      end else begin
         remainder_ff  <= remainder_in;
         in_message_ff <= in_message_in;
         out_wr_ff     <= out_wr_in;
         out_rd_ff     <= out_rd_in;
         out_cnt_ff    <= out_cnt_in;
      end
      if (out_push) begin
         out_mem_ff[out_wr_ff] <= crc;
      end
   end

endmodule

### rtl/configurable_crc_engine_unit.sv
`timescale 1ns / 1ps

// Byte-wide CRC engine (Rocksoft model) with a programmable width of 8 to 32
// bits, polynomial, initial value, input/output reflection and final xor.
// Push one message byte per cycle while req_full is low; the byte flagged
// last yields one word on the result side holding the finished CRC (upper
// bits zero for narrow CRCs), and the next byte starts a new message from
// the initial value. The engine sustains one byte per clock while the
// result buffer has room: all eight shift steps of a byte are done
// combinationally by the back stage. A result passes the input register,
// then the four-word queue (the CRC stage works as the word leaves it),
// and a two-word result buffer lets input keep flowing while results wait.
// Write the registers only while the engine is idle; out-of-range widths are
// clamped to 8 or 32.
module configurable_crc_engine_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 req_last_byte,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [31:0]                          rsp_crc_value,
   input  logic                                 csr_write_en,
   input  logic [crce_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [31:0]                          csr_data
);

   crce_pkg::cfg_type  cfg_ff, cfg_in;
   crce_pkg::item_type front_item, back_item;
   logic               q_push, q_full, q_pop, q_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            crce_pkg::CSR_CRC_WIDTH:      cfg_in.crc_width      = csr_data[5:0];
            crce_pkg::CSR_POLYNOMIAL:     cfg_in.polynomial     = csr_data;
            crce_pkg::CSR_INITIAL_VALUE:  cfg_in.initial_value  = csr_data;
            crce_pkg::CSR_REFLECT_INPUT:  cfg_in.reflect_input  = csr_data[0];
            crce_pkg::CSR_REFLECT_OUTPUT: cfg_in.reflect_output = csr_data[0];
            crce_pkg::CSR_FINAL_XOR:      cfg_in.final_xor      = csr_data;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crc_width      <= crce_pkg::RESET_CRC_WIDTH;
         cfg_ff.polynomial     <= crce_pkg::RESET_POLYNOMIAL;
         cfg_ff.initial_value  <= crce_pkg::RESET_INITIAL_VALUE;
         cfg_ff.reflect_input  <= crce_pkg::RESET_REFLECT_INPUT;
         cfg_ff.reflect_output <= crce_pkg::RESET_REFLECT_OUTPUT;
         cfg_ff.final_xor      <= crce_pkg::RESET_FINAL_XOR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   crce_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .req_full      (req_full),
      .reflect_input (cfg_ff.reflect_input),
      .q_push        (q_push),
      .q_item        (front_item),
      .q_full        (q_full)
   );

   crce_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (back_item),
      .empty     (q_empty)
   );

   crce_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .q_empty       (q_empty),
      .q_item        (back_item),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_crc_value (rsp_crc_value)
   );

endmodule

### verif/tb_configurable_crc_engine_unit.sv
`timescale 1ns / 1ps

module tb_configurable_crc_engine_unit;

   localparam int ClockPeriod   = 20;
   localparam int ResetCycles   = 6;
   localparam int SettleCycles  = 12;
   localparam int HoldCycles    = 150;
   localparam int TimeoutCycles = 250000;
   localparam int SegmentBytes  = 64;
   localparam int SegmentCount  = 6;

   localparam logic [crce_pkg::CsrIndexWidth-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [crce_pkg::CsrIndexWidth-1:0] CSR_SPARE_HI = 3'd7;

   localparam logic [31:0] CRC8_POLY   = 32'h0000_00D5;
   localparam logic [31:0] CCITT_POLY  = 32'hFFFF_1021;

   typedef enum logic { ROW_BYTE, ROW_CSR } row_kind_type;

   typedef struct {
      row_kind_type                        kind;
      logic [crce_pkg::CsrIndexWidth-1:0]  index;
      logic [31:0]                         value;
      logic                                last;
      logic                                known;
      logic [31:0]                         crc;
   } stim_row_type;

   logic                                clock         = 1'b0;
   logic                                reset         = 1'b1;
   logic                                req_push      = 1'b0;
   logic                                req_full;
   logic [7:0]                          req_data_byte = 8'h00;
   logic                                req_last_byte = 1'b0;
   logic                                rsp_empty;
   logic                                rsp_pop       = 1'b0;
   logic [31:0]                         rsp_crc_value;
   logic                                csr_write_en  = 1'b0;
   logic [crce_pkg::CsrIndexWidth-1:0]  csr_index     = '0;
   logic [31:0]                         csr_data      = 32'h0;

   // predictor copy of the registers and running state
   logic [5:0]  cfg_width;
   logic [31:0] cfg_poly;
   logic [31:0] cfg_init;
   logic        cfg_refin;
   logic        cfg_refout;
   logic [31:0] cfg_xor;
   logic [31:0] crc_rem;
   logic        crc_open;

   logic [31:0]  pending_crcs[$];
   stim_row_type directed_rows[$];
   int           mismatch_count = 0;
   int           send_idle_pct  = 0;
   int           recv_idle_pct  = 0;
   int           msg_left       = 0;
   int           hold_req       = 0;
   int           hold_seen      = 0;
   int           hold_left      = 0;

   configurable_crc_engine_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_crc_value (rsp_crc_value),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   function automatic void apply_csr(input logic [crce_pkg::CsrIndexWidth-1:0] idx,
                                     input logic [31:0] val);
      case (idx)
         crce_pkg::CSR_CRC_WIDTH:      cfg_width  = val[5:0];
         crce_pkg::CSR_POLYNOMIAL:     cfg_poly   = val;
         crce_pkg::CSR_INITIAL_VALUE:  cfg_init   = val;
         crce_pkg::CSR_REFLECT_INPUT:  cfg_refin  = val[0];
         crce_pkg::CSR_REFLECT_OUTPUT: cfg_refout = val[0];
         crce_pkg::CSR_FINAL_XOR:      cfg_xor    = val;
         default: ;
      endcase
   endfunction

   // advance the running remainder by one byte; returns the finished CRC on a last byte
   function automatic logic [31:0] crc_absorb(input logic [7:0] data, input logic last);
      int unsigned w;
      logic [31:0] mask;
      logic [31:0] top;
      logic [31:0] poly;
      logic [31:0] r;
      logic [31:0] rev;
      logic [7:0]  b;
      w = (cfg_width < 6'd8) ? 8 : (cfg_width > 6'd32) ? 32 : int'(cfg_width);
      mask = (w == 32) ? 32'hFFFF_FFFF : ((32'h1 << w) - 32'h1);
      top  = 32'h1 << (w - 1);
      poly = cfg_poly & mask;
      if (!crc_open) begin
         crc_rem = cfg_init & mask;
      end
      crc_open = 1'b1;
      b = data;
      if (cfg_refin) begin
         for (int i = 0; i < 8; i++) b[i] = data[7-i];
      end
      r = (crc_rem & mask) ^ ({24'h0, b} << (w - 8));
      for (int i = 0; i < 8; i++) begin
         if ((r & top) != 32'h0) r = ((r << 1) ^ poly) & mask;
         else r = (r << 1) & mask;
      end
      crc_rem = r;
      if (last) begin
         if (cfg_refout) begin
            for (int i = 0; i < 32; i++) rev[i] = r[31-i];
            r = rev >> (32 - w);
         end
         r = (r ^ cfg_xor) & mask;
         crc_rem  = cfg_init & mask;
         crc_open = 1'b0;
      end
      return r;
   endfunction

   function automatic stim_row_type byte_row(input logic [7:0] data, input logic last,
                                             input logic known, input logic [31:0] crc);
      stim_row_type row;
      row.kind  = ROW_BYTE;
      row.index = '0;
      row.value = {24'h0, data};
      row.last  = last;
      row.known = known;
      row.crc   = crc;
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [crce_pkg::CsrIndexWidth-1:0] idx,
                                            input logic [31:0] val);
      stim_row_type row;
      row.kind  = ROW_CSR;
      row.index = idx;
      row.value = val;
      row.last  = 1'b0;
      row.known = 1'b0;
      row.crc   = 32'h0;
      return row;
   endfunction

   task automatic send_byte(input logic [7:0] data, input logic last,
                            input logic known, input logic [31:0] crc);
      logic [31:0] predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push      <= 1'b1;
      req_data_byte <= data;
      req_last_byte <= last;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predicted = crc_absorb(data, last);
      if (last) pending_crcs.push_back(known ? crc : predicted);
   endtask

   // write enable stays high; the caller drops it after the last write
   task automatic csr_write(input logic [crce_pkg::CsrIndexWidth-1:0] idx,
                            input logic [31:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= val;
      @(posedge clock);
      apply_csr(idx, val);
   endtask

   task automatic wait_drain();
      req_push <= 1'b0;
      while (pending_crcs.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(5))
         0:       return 32'h0;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic pick_crc_setup();
      logic [31:0] junk;
      logic [5:0]  w;
      junk = $urandom;
      case ($urandom_range(3))
         0: begin
            csr_write(crce_pkg::CSR_CRC_WIDTH, 32'd32);
            csr_write(crce_pkg::CSR_POLYNOMIAL, crce_pkg::RESET_POLYNOMIAL);
            csr_write(crce_pkg::CSR_INITIAL_VALUE, 32'hFFFF_FFFF);
            csr_write(crce_pkg::CSR_REFLECT_INPUT, 32'd1);
            csr_write(crce_pkg::CSR_REFLECT_OUTPUT, 32'd1);
            csr_write(crce_pkg::CSR_FINAL_XOR, 32'hFFFF_FFFF);
         end
         1: begin
            csr_write(crce_pkg::CSR_CRC_WIDTH, 32'd32);
            csr_write(crce_pkg::CSR_POLYNOMIAL, crce_pkg::RESET_POLYNOMIAL);
            csr_write(crce_pkg::CSR_INITIAL_VALUE, 32'h0);
            csr_write(crce_pkg::CSR_REFLECT_INPUT, 32'd0);
            csr_write(crce_pkg::CSR_REFLECT_OUTPUT, 32'd0);
            csr_write(crce_pkg::CSR_FINAL_XOR, 32'hFFFF_FFFF);
         end
         2: begin
            csr_write(crce_pkg::CSR_CRC_WIDTH, 32'd8);
            csr_write(crce_pkg::CSR_POLYNOMIAL, CRC8_POLY);
            csr_write(crce_pkg::CSR_INITIAL_VALUE, 32'h0);
            csr_write(crce_pkg::CSR_REFLECT_INPUT, 32'd0);
            csr_write(crce_pkg::CSR_REFLECT_OUTPUT, 32'd0);
            csr_write(crce_pkg::CSR_FINAL_XOR, 32'h0);
         end
         default: begin
            case ($urandom_range(7))
               0:       w = 6'd8;
               1:       w = 6'd32;
               2:       w = 6'd0;
               3:       w = 6'd63;
               4:       w = 6'd7;
               5:       w = 6'd33;
               default: w = 6'($urandom_range(63));
            endcase
            // upper bits of narrow registers must be ignored
            csr_write(crce_pkg::CSR_CRC_WIDTH, {junk[31:6], w});
            csr_write(crce_pkg::CSR_POLYNOMIAL, pick_word());
            csr_write(crce_pkg::CSR_INITIAL_VALUE, pick_word());
            csr_write(crce_pkg::CSR_REFLECT_INPUT, $urandom);
            csr_write(crce_pkg::CSR_REFLECT_OUTPUT, $urandom);
            csr_write(crce_pkg::CSR_FINAL_XOR, pick_word());
         end
      endcase
      if ($urandom_range(3) == 0) csr_write($urandom_range(1) ? CSR_SPARE_HI : CSR_SPARE_LO,
                                            $urandom);
   endtask

   task automatic send_messages(input int count);
      logic last;
      for (int k = 0; k < count; k++) begin
         if (msg_left == 0) begin
            msg_left = ($urandom_range(9) == 0) ? $urandom_range(24, 1) : $urandom_range(6, 1);
         end
         last = (msg_left == 1);
         msg_left--;
         send_byte(8'($urandom_range(255)), last, 1'b0, 32'h0);
         // hold input until the engine has handed back everything
         if ($urandom_range(49) == 0 && pending_crcs.size() != 0) begin
            req_push <= 1'b0;
            while (pending_crcs.size() != 0) @(posedge clock);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (pending_crcs.size() == 0) begin
               mismatch_count++;
               $display("%0t crc_value unexpected word: expected none actual %h",
                        $time, rsp_crc_value);
            end else begin
               if (rsp_crc_value !== pending_crcs[0]) begin
                  mismatch_count++;
                  $display("%0t crc_value mismatch: expected %h actual %h",
                           $time, pending_crcs[0], rsp_crc_value);
               end
               void'(pending_crcs.pop_front());
            end
         end
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      #(TimeoutCycles * ClockPeriod);
      $display("tb_configurable_crc_engine_unit: FAIL");
      $finish;
   end

   initial begin
      logic prev_csr;
      cfg_width  = crce_pkg::RESET_CRC_WIDTH;
      cfg_poly   = crce_pkg::RESET_POLYNOMIAL;
      cfg_init   = crce_pkg::RESET_INITIAL_VALUE;
      cfg_refin  = crce_pkg::RESET_REFLECT_INPUT;
      cfg_refout = crce_pkg::RESET_REFLECT_OUTPUT;
      cfg_xor    = crce_pkg::RESET_FINAL_XOR;
      crc_rem    = 32'h0;
      crc_open   = 1'b0;

      // reset settings are the reflected CRC-32
      directed_rows.push_back(byte_row(8'h00, 1'b1, 1'b1, 32'hD202_EF8D));
      directed_rows.push_back(byte_row(8'hFF, 1'b1, 1'b1, 32'hFF00_0000));
      for (int i = 1; i <= 8; i++) begin
         directed_rows.push_back(byte_row(8'(8'h30 + i), 1'b0, 1'b0, 0));
      end
      directed_rows.push_back(byte_row(8'h39, 1'b1, 1'b1, 32'hCBF4_3926));
      directed_rows.push_back(csr_row(crce_pkg::CSR_CRC_WIDTH, 32'd8));
      directed_rows.push_back(csr_row(crce_pkg::CSR_POLYNOMIAL, CRC8_POLY));
      directed_rows.push_back(csr_row(crce_pkg::CSR_INITIAL_VALUE, 32'h0));
      directed_rows.push_back(csr_row(crce_pkg::CSR_REFLECT_INPUT, 32'd0));
      directed_rows.push_back(csr_row(crce_pkg::CSR_REFLECT_OUTPUT, 32'd0));
      directed_rows.push_back(csr_row(crce_pkg::CSR_FINAL_XOR, 32'h0));
      // zero message through zero start and zero xor stays zero
      directed_rows.push_back(byte_row(8'h00, 1'b1, 1'b1, 32'h0));
      directed_rows.push_back(byte_row(8'hFF, 1'b0, 1'b0, 0));
      directed_rows.push_back(byte_row(8'h80, 1'b1, 1'b0, 0));
      // width above range clamps to 32
      directed_rows.push_back(csr_row(crce_pkg::CSR_CRC_WIDTH, 32'd63));
      directed_rows.push_back(csr_row(crce_pkg::CSR_POLYNOMIAL, crce_pkg::RESET_POLYNOMIAL));
      directed_rows.push_back(csr_row(crce_pkg::CSR_FINAL_XOR, 32'hFFFF_FFFF));
      directed_rows.push_back(byte_row(8'h31, 1'b0, 1'b0, 0));
      directed_rows.push_back(byte_row(8'h32, 1'b1, 1'b0, 0));
      // width below range clamps to 8
      directed_rows.push_back(csr_row(crce_pkg::CSR_CRC_WIDTH, 32'd0));
      directed_rows.push_back(csr_row(crce_pkg::CSR_INITIAL_VALUE, 32'hFFFF_FFFF));
      directed_rows.push_back(csr_row(crce_pkg::CSR_REFLECT_INPUT, 32'd1));
      directed_rows.push_back(byte_row(8'hA5, 1'b0, 1'b0, 0));
      // settings change with the message still open
      directed_rows.push_back(csr_row(crce_pkg::CSR_CRC_WIDTH, 32'd16));
      directed_rows.push_back(csr_row(crce_pkg::CSR_POLYNOMIAL, CCITT_POLY));
      directed_rows.push_back(csr_row(crce_pkg::CSR_REFLECT_OUTPUT, 32'd1));
      directed_rows.push_back(csr_row(CSR_SPARE_LO, 32'hFFFF_FFFF));
      directed_rows.push_back(csr_row(CSR_SPARE_HI, 32'h0000_0001));
      directed_rows.push_back(byte_row(8'h5A, 1'b1, 1'b0, 0));
      directed_rows.push_back(byte_row(8'h7E, 1'b1, 1'b0, 0));

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      prev_csr = 1'b0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            if (!prev_csr) wait_drain();
            csr_write(directed_rows[i].index, directed_rows[i].value);
            prev_csr = 1'b1;
         end else begin
            if (prev_csr) csr_write_en <= 1'b0;
            send_byte(directed_rows[i].value[7:0], directed_rows[i].last,
                      directed_rows[i].known, directed_rows[i].crc);
            prev_csr = 1'b0;
         end
      end

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 37;
               recv_idle_pct = 73;
            end
            1: begin
               send_idle_pct = 73;
               recv_idle_pct = 37;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int seg = 0; seg < SegmentCount; seg++) begin
            wait_drain();
            pick_crc_setup();
            csr_write_en <= 1'b0;
            // stall the result side long enough to back up the input
            if (mode == 2 && seg == 0) hold_req++;
            send_messages(SegmentBytes);
         end
      end

      wait_drain();
      if (mismatch_count == 0) begin
         $display("tb_configurable_crc_engine_unit: PASS");
      end else begin
         $display("tb_configurable_crc_engine_unit: FAIL");
      end
      $finish;
   end

endmodule

### configurable_crc_engine_unit.f
rtl/crce_pkg.sv
rtl/crce_front.sv
rtl/crce_queue.sv
rtl/crce_back.sv
rtl/configurable_crc_engine_unit.sv
verif/tb_configurable_crc_engine_unit.sv
